// ----- hdl/bud_alloc_pkg.sv -----
// Shared types, codes and default sizes of the buddy allocator.
package bud_alloc_pkg;

   // Default heap geometry
   localparam int MIN_SHIFT_DEF    = 5;
   localparam int LEVEL_COUNT_DEF  = 11;
   localparam int HEADER_BYTES_DEF = 24;

   // Request kind carried in tuser
   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   // Result status carried in tuser
   typedef enum logic [1:0] {
      R_ALLOC   = 2'd0,
      R_REFUSED = 2'd1,
      R_FREED   = 2'd2,
      R_IGNORED = 2'd3
   } rstat_type;

   // Per-unit block marking held in the status store
   typedef enum logic [1:0] {
      B_NONE = 2'd0,
      B_FREE = 2'd1,
      B_USED = 2'd2
   } bstat_type;

   // Sequencer states
   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_NEED,
      S_SEARCH,
      S_TAKE,
      S_SPLIT,
      S_PUSH,
      S_PUSH2,
      S_FCHK,
      S_FSTAT,
      S_MERGE,
      S_MCHK,
      S_ULD,
      S_UL2,
      S_DONE
   } state_type;

   // One request word
   typedef struct packed {
      op_type      operation;
      logic [31:0] request_size;
      logic [14:0] user_offset;
   } req_type;

   // One result word
   typedef struct packed {
      rstat_type   status;
      logic [15:0] free_bytes;
      logic [3:0]  granted_level;
      logic [14:0] granted_offset;
   } rsp_type;

endpackage

// ----- hdl/bud_alloc_ctrl.sv -----
// Allocator sequencer with the block status store and the free-list link store.
module bud_alloc_ctrl
   import bud_alloc_pkg::*;
#(
   parameter int MIN_SHIFT    = MIN_SHIFT_DEF,
   parameter int LEVEL_COUNT  = LEVEL_COUNT_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req,
   input  logic    take,
   output logic    done,
   output rsp_type rsp
);

   localparam int TOP     = LEVEL_COUNT - 1;
   localparam int UNIT_W  = LEVEL_COUNT - 1;
   localparam int UNITS   = 1 << UNIT_W;
   localparam int LINK_W  = LEVEL_COUNT;
   localparam int LVL_W   = (LEVEL_COUNT > 2) ? $clog2(LEVEL_COUNT) : 1;
   localparam int FREE_W  = MIN_SHIFT + LEVEL_COUNT;
   localparam int TOT_W   = (FREE_W > 33) ? FREE_W : 33;
   localparam int STAT_W  = 2 + LVL_W;
   localparam logic [LINK_W-1:0] EMPTY = LINK_W'(UNITS);
   localparam logic [UNIT_W-1:0] LAST_UNIT = UNIT_W'(UNITS - 1);

   // Stores
   logic [STAT_W-1:0]   stat_mem [UNITS];
   logic [2*LINK_W-1:0] link_mem [UNITS];

   logic                stat_we;
   logic [UNIT_W-1:0]   stat_waddr, stat_raddr;
   logic [STAT_W-1:0]   stat_wdata, stat_rdata_ff;
   logic                link_we_lo, link_we_hi;
   logic [UNIT_W-1:0]   link_waddr, link_raddr;
   logic [LINK_W-1:0]   link_wdata_lo, link_wdata_hi;
   logic [2*LINK_W-1:0] link_rdata_ff;

   // Registers
   state_type           state_ff, state_in;
   op_type              op_ff, op_in;
   logic [TOT_W-1:0]    total_ff, total_in;
   logic                zero_ff, zero_in;
   logic [14:0]         uoff_ff, uoff_in;
   logic [UNIT_W-1:0]   u_ff, u_in, v_ff, v_in, clr_ff, clr_in;
   logic [LINK_W-1:0]   h_ff, h_in, n_ff, n_in;
   logic [LVL_W-1:0]    lvl_ff, lvl_in, need_ff, need_in;
   logic [LINK_W-1:0]   head_ff [LEVEL_COUNT];
   logic [LINK_W-1:0]   head_in [LEVEL_COUNT];
   logic [FREE_W-1:0]   free_ff, free_in;
   rsp_type             rsp_ff, rsp_in;

   // Size decode and free pointer checks
   logic [LVL_W-1:0]    need_c;
   logic                fits_c;
   logic [14:0]         off_c, unit15_c;
   logic [31:0]         unit32_c, goff_c;
   logic                bad_ptr_c;
   logic [LVL_W-1:0]    slvl_c;
   logic [LINK_W-1:0]   head_c;

   // Read, write and hold the status store
   always_ff @(posedge clock) begin
      if (stat_we) begin
         stat_mem[stat_waddr] <= stat_wdata;
      end
      stat_rdata_ff <= stat_mem[stat_raddr];
   end

   // Read and write the link store; next in the low lane, prev in the high lane
   always_ff @(posedge clock) begin
      if (link_we_lo) begin
         link_mem[link_waddr][LINK_W-1:0] <= link_wdata_lo;
      end
      if (link_we_hi) begin
         link_mem[link_waddr][2*LINK_W-1:LINK_W] <= link_wdata_hi;
      end
      link_rdata_ff <= link_mem[link_raddr];
   end

   // Find the lowest level that holds the request with its header
   always_comb begin
      need_c = LVL_W'(TOP);
      for (int l = TOP; l >= 0; l--) begin
         if ((TOT_W'(1) << (MIN_SHIFT + l)) >= total_ff) begin
            need_c = LVL_W'(l);
         end
      end
      fits_c = (TOT_W'(1) << (MIN_SHIFT + TOP)) >= total_ff;
   end

   // Check a pointer to be freed
   always_comb begin
      off_c     = uoff_ff - 15'(HEADER_BYTES);
      unit15_c  = off_c >> MIN_SHIFT;
      unit32_c  = 32'(unit15_c);
      bad_ptr_c = (uoff_ff < 15'(HEADER_BYTES)) || (off_c[MIN_SHIFT-1:0] != '0) ||
                  (unit32_c >= 32'(UNITS));
   end

   assign slvl_c = (stat_rdata_ff[LVL_W-1:0] > LVL_W'(TOP)) ? LVL_W'(TOP)
                                                             : stat_rdata_ff[LVL_W-1:0];
   assign head_c = head_ff[lvl_ff];
   assign goff_c = (32'(u_ff) << MIN_SHIFT) + 32'(HEADER_BYTES);

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         free_ff  <= FREE_W'(1) << (MIN_SHIFT + TOP);
         for (int l = 0; l < LEVEL_COUNT; l++) begin
            head_ff[l] <= (l == TOP) ? '0 : EMPTY;
         end
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         free_ff  <= free_in;
         head_ff  <= head_in;
      end
      op_ff    <= op_in;
      total_ff <= total_in;
      zero_ff  <= zero_in;
      uoff_ff  <= uoff_in;
      u_ff     <= u_in;
      v_ff     <= v_in;
      h_ff     <= h_in;
      n_ff     <= n_in;
      lvl_ff   <= lvl_in;
      need_ff  <= need_in;
      rsp_ff   <= rsp_in;
   end

   // Next state, store accesses and result
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      total_in = total_ff;
      zero_in  = zero_ff;
      uoff_in  = uoff_ff;
      u_in     = u_ff;
      v_in     = v_ff;
      h_in     = h_ff;
      n_in     = n_ff;
      lvl_in   = lvl_ff;
      need_in  = need_ff;
      clr_in   = clr_ff;
      free_in  = free_ff;
      head_in  = head_ff;
      rsp_in   = rsp_ff;

      stat_we       = 1'b0;
      stat_waddr    = v_ff;
      stat_wdata    = '0;
      stat_raddr    = u_ff;
      link_we_lo    = 1'b0;
      link_we_hi    = 1'b0;
      link_waddr    = v_ff;
      link_wdata_lo = EMPTY;
      link_wdata_hi = EMPTY;
      link_raddr    = u_ff;
      req_ready     = 1'b0;
      done          = 1'b0;

      case (state_ff)
         // Sweep the status store, leaving one free top block
         S_CLEAR: begin
            stat_we    = 1'b1;
            stat_waddr = clr_ff;
            if (clr_ff == '0) begin
               stat_wdata = {B_FREE, LVL_W'(TOP)};
               link_we_lo = 1'b1;
               link_we_hi = 1'b1;
               link_waddr = '0;
            end
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_UNIT) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in    = req.operation;
               total_in = TOT_W'(req.request_size) + TOT_W'(HEADER_BYTES);
               zero_in  = (req.request_size == '0);
               uoff_in  = req.user_offset;
               state_in = (req.operation == OP_FREE) ? S_FCHK : S_NEED;
            end
         end
         S_NEED: begin
            if (zero_ff || !fits_c) begin
               rsp_in   = '{status: R_REFUSED, free_bytes: 16'(free_ff),
                            granted_level: '0, granted_offset: '0};
               state_in = S_DONE;
            end else begin
               need_in  = need_c;
               lvl_in   = need_c;
               state_in = S_SEARCH;
            end
         end
         // Walk up the free lists one level a cycle
         S_SEARCH: begin
            if (!head_c[LINK_W-1]) begin
               u_in       = head_c[UNIT_W-1:0];
               link_raddr = head_c[UNIT_W-1:0];
               state_in   = S_TAKE;
            end else if (lvl_ff == LVL_W'(TOP)) begin
               rsp_in   = '{status: R_REFUSED, free_bytes: 16'(free_ff),
                            granted_level: '0, granted_offset: '0};
               state_in = S_DONE;
            end else begin
               lvl_in = lvl_ff + 1'b1;
            end
         end
         // Pop the list head
         S_TAKE: begin
            head_in[lvl_ff] = link_rdata_ff[LINK_W-1:0];
            if (!link_rdata_ff[LINK_W-1]) begin
               link_we_hi = 1'b1;
               link_waddr = link_rdata_ff[UNIT_W-1:0];
            end
            state_in = S_SPLIT;
         end
         // Split down, or mark the block used
         S_SPLIT: begin
            if (lvl_ff > need_ff) begin
               lvl_in   = lvl_ff - 1'b1;
               v_in     = u_ff | (UNIT_W'(1) << (lvl_ff - 1'b1));
               state_in = S_PUSH;
            end else begin
               stat_we    = 1'b1;
               stat_waddr = u_ff;
               stat_wdata = {B_USED, need_ff};
               free_in    = free_ff - (FREE_W'(1) << (MIN_SHIFT + 32'(need_ff)));
               rsp_in     = '{status: R_ALLOC, free_bytes: 16'(free_in),
                              granted_level: 4'(need_ff), granted_offset: goff_c[14:0]};
               state_in   = S_DONE;
            end
         end
         // Push block v at the head of its list
         S_PUSH: begin
            h_in          = head_c;
            link_we_lo    = 1'b1;
            link_we_hi    = 1'b1;
            link_wdata_lo = head_c;
            stat_we       = 1'b1;
            stat_wdata    = {B_FREE, lvl_ff};
            head_in[lvl_ff] = LINK_W'(v_ff);
            state_in      = S_PUSH2;
         end
         S_PUSH2: begin
            if (!h_ff[LINK_W-1]) begin
               link_we_hi    = 1'b1;
               link_waddr    = h_ff[UNIT_W-1:0];
               link_wdata_hi = LINK_W'(v_ff);
            end
            if (op_ff == OP_ALLOC) begin
               state_in = S_SPLIT;
            end else begin
               rsp_in   = '{status: R_FREED, free_bytes: 16'(free_ff),
                            granted_level: 4'(lvl_ff), granted_offset: '0};
               state_in = S_DONE;
            end
         end
         S_FCHK: begin
            if (bad_ptr_c) begin
               rsp_in   = '{status: R_IGNORED, free_bytes: 16'(free_ff),
                            granted_level: '0, granted_offset: '0};
               state_in = S_DONE;
            end else begin
               u_in       = unit32_c[UNIT_W-1:0];
               stat_raddr = unit32_c[UNIT_W-1:0];
               state_in   = S_FSTAT;
            end
         end
         S_FSTAT: begin
            if (stat_rdata_ff[STAT_W-1:LVL_W] != B_USED) begin
               rsp_in   = '{status: R_IGNORED, free_bytes: 16'(free_ff),
                            granted_level: '0, granted_offset: '0};
               state_in = S_DONE;
            end else begin
               lvl_in   = slvl_c;
               free_in  = free_ff + (FREE_W'(1) << (MIN_SHIFT + 32'(slvl_c)));
               state_in = S_MERGE;
            end
         end
         // Look at the buddy of the current level
         S_MERGE: begin
            if (lvl_ff < LVL_W'(TOP)) begin
               v_in       = u_ff ^ (UNIT_W'(1) << lvl_ff);
               stat_raddr = u_ff ^ (UNIT_W'(1) << lvl_ff);
               state_in   = S_MCHK;
            end else begin
               v_in     = u_ff;
               state_in = S_PUSH;
            end
         end
         S_MCHK: begin
            if (stat_rdata_ff == {B_FREE, lvl_ff}) begin
               link_raddr = v_ff;
               state_in   = S_ULD;
            end else begin
               v_in     = u_ff;
               state_in = S_PUSH;
            end
         end
         // Unlink the buddy: fix the forward side
         S_ULD: begin
            h_in = link_rdata_ff[2*LINK_W-1:LINK_W];
            n_in = link_rdata_ff[LINK_W-1:0];
            if (!link_rdata_ff[2*LINK_W-1]) begin
               link_we_lo    = 1'b1;
               link_waddr    = link_rdata_ff[LINK_W+UNIT_W-1:LINK_W];
               link_wdata_lo = link_rdata_ff[LINK_W-1:0];
            end else begin
               head_in[lvl_ff] = link_rdata_ff[LINK_W-1:0];
            end
            state_in = S_UL2;
         end
         // Fix the backward side and drop the upper block start
         S_UL2: begin
            if (!n_ff[LINK_W-1]) begin
               link_we_hi    = 1'b1;
               link_waddr    = n_ff[UNIT_W-1:0];
               link_wdata_hi = h_ff;
            end
            stat_we = 1'b1;
            if (v_ff < u_ff) begin
               stat_waddr = u_ff;
               u_in       = v_ff;
            end else begin
               stat_waddr = v_ff;
            end
            lvl_in   = lvl_ff + 1'b1;
            state_in = S_MERGE;
         end
         S_DONE: begin
            done = 1'b1;
            if (take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp = rsp_ff;

endmodule

// ----- hdl/buddy_allocator.sv -----
// Binary buddy allocator: stream ports, result register and sequencer.
//
// Requests arrive on req_ (tuser = operation: 0 allocate, 1 free). Each
// request gives exactly one result word on rsp_ (tuser = status).
// Allocate returns the user offset (block start plus the header) and the
// block level; free returns the level of the finally merged block. Every
// result carries the free-byte count after the request.
// One request is worked at a time. Allocate decodes the size, walks up the
// free lists, pops a block and splits it down level by level; a zero or
// oversized request is refused after the size decode. Free checks the pointer,
// reads the block status and merges with each free buddy before it pushes the
// merged block; an ignored free ends after the pointer or status check. The
// sequencer then goes back to idle before the next request is taken. The pace
// is set by the one-read, one-write port of the status and link stores, which every list step goes through.
// After reset the block sweeps the status store, one unit a cycle, over all
// 2^(LEVEL_COUNT-1) units (1024 by default), with req_tready low; the
// heap then holds one free top block.
// A stalled receiver holds the result register; the next request is taken
// once the sequencer has handed over its result, so nothing is lost.
module buddy_allocator
   import bud_alloc_pkg::*;
#(
   parameter int MIN_SHIFT    = MIN_SHIFT_DEF,
   parameter int LEVEL_COUNT  = LEVEL_COUNT_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // request_size[31:0], user_offset[46:32]
   input  logic        req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // granted_offset[14:0], granted_level[18:15],
                                    // free_bytes[34:19]
   output logic [1:0]  rsp_tuser    // status
);

   req_type req_c;
   rsp_type ctrl_rsp;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    take_c, done_c;

   // Unpack the request word
   assign req_c = '{operation: op_type'(req_tuser), request_size: req_tdata[31:0],
                    user_offset: req_tdata[46:32]};

   bud_alloc_ctrl #(
      .MIN_SHIFT    (MIN_SHIFT),
      .LEVEL_COUNT  (LEVEL_COUNT),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req_c),
      .take      (take_c),
      .done      (done_c),
      .rsp       (ctrl_rsp)
   );

   // Load the result register when it is empty or being drained
   assign take_c = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (take_c) begin
         rsp_valid_in = done_c;
         if (done_c) begin
            rsp_in = ctrl_rsp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   // Pack the result word
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {5'b0, rsp_ff.free_bytes, rsp_ff.granted_level,
                        rsp_ff.granted_offset};

endmodule

// ----- tb/buddy_allocator_checker.sv -----
// Checker for the buddy allocator: watches both channels, predicts and compares results.
module buddy_allocator_checker
   import bud_alloc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,   // request_size[31:0], user_offset[46:32]
   input  logic        req_tuser,   // operation
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // granted_offset[14:0], granted_level[18:15],
                                    // free_bytes[34:19]
   input  logic [1:0]  rsp_tuser,   // status
   output int          fail_count,
   output int          pending,
   output int          alloc_seen,
   output int          freed_seen,
   output int          refused_seen,
   output int          ignored_seen
);

   localparam int TOP   = LEVEL_COUNT_DEF - 1;
   localparam int UNITS = 1 << TOP;
   localparam int NIL   = UNITS;

   typedef struct packed {
      rstat_type   status;
      logic [14:0] offset;
      logic [3:0]  level;
      logic [15:0] free_bytes;
   } outcome_type;

   int          heads [LEVEL_COUNT_DEF];
   bstat_type   marks [UNITS];
   int          lvls  [UNITS];
   int          prv   [UNITS];
   int          nxt   [UNITS];
   int          free_sum;
   outcome_type awaited[$];

   // link a block at the head of its free list
   function automatic void list_push(int u, int l);
      prv[u] = NIL;
      nxt[u] = heads[l];
      if (heads[l] < UNITS) prv[heads[l]] = u;
      heads[l] = u;
      marks[u] = B_FREE;
      lvls[u] = l;
   endfunction

   function automatic void list_drop(int u, int l);
      int p, n;
      p = prv[u];
      n = nxt[u];
      if (p < UNITS) nxt[p] = n;
      else heads[l] = n;
      if (n < UNITS) prv[n] = p;
      prv[u] = NIL;
      nxt[u] = NIL;
   endfunction

   function automatic void heap_reset();
      for (int i = 0; i < LEVEL_COUNT_DEF; i++) heads[i] = NIL;
      for (int i = 0; i < UNITS; i++) begin
         marks[i] = B_NONE;
         lvls[i] = 0;
         prv[i] = 0;
         nxt[i] = 0;
      end
      list_push(0, TOP);
      free_sum = UNITS << MIN_SHIFT_DEF;
   endfunction

   // work out the result of one request and advance the heap
   function automatic outcome_type heap_step(op_type op, logic [31:0] size,
                                             logic [14:0] uoff);
      outcome_type r;
      longint total;
      int need, l, u, b, off;
      r = '0;
      if (op == OP_ALLOC) begin
         r.status = R_REFUSED;
         total = longint'(size) + HEADER_BYTES_DEF;
         need = 0;
         while (need < LEVEL_COUNT_DEF && (longint'(1) << (MIN_SHIFT_DEF + need)) < total)
            need++;
         if (size != 0 && need < LEVEL_COUNT_DEF) begin
            l = need;
            while (l < LEVEL_COUNT_DEF && heads[l] >= UNITS) l++;
            if (l < LEVEL_COUNT_DEF) begin
               u = heads[l];
               list_drop(u, l);
               while (l > need) begin
                  l--;
                  list_push(u + (1 << l), l);
               end
               marks[u] = B_USED;
               lvls[u] = need;
               free_sum -= 1 << (MIN_SHIFT_DEF + need);
               r.status = R_ALLOC;
               r.offset = 15'((u << MIN_SHIFT_DEF) + HEADER_BYTES_DEF);
               r.level = 4'(need);
            end
         end
      end else begin
         r.status = R_IGNORED;
         off = int'(uoff) - HEADER_BYTES_DEF;
         if (off >= 0 && off % (1 << MIN_SHIFT_DEF) == 0 && (off >> MIN_SHIFT_DEF) < UNITS
             && marks[off >> MIN_SHIFT_DEF] == B_USED) begin
            u = off >> MIN_SHIFT_DEF;
            l = lvls[u];
            free_sum += 1 << (MIN_SHIFT_DEF + l);
            // merge with free buddies of equal level
            while (l < TOP) begin
               b = u ^ (1 << l);
               if (marks[b] != B_FREE || lvls[b] != l) break;
               list_drop(b, l);
               if (b < u) begin
                  marks[u] = B_NONE;
                  lvls[u] = 0;
                  u = b;
               end else begin
                  marks[b] = B_NONE;
                  lvls[b] = 0;
               end
               l++;
            end
            list_push(u, l);
            r.status = R_FREED;
            r.level = 4'(l);
         end
      end
      r.free_bytes = 16'(free_sum);
      return r;
   endfunction

   assign pending = awaited.size();

   always @(posedge clock) begin
      outcome_type want, got;
      if (reset) begin
         heap_reset();
         awaited.delete();
         fail_count <= 0;
         alloc_seen <= 0;
         freed_seen <= 0;
         refused_seen <= 0;
         ignored_seen <= 0;
      end else begin
         // predict each accepted request
         if (req_tvalid && req_tready)
            awaited.push_back(heap_step(op_type'(req_tuser), req_tdata[31:0],
                                        req_tdata[46:32]));
         // compare each accepted result word with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got.status = rstat_type'(rsp_tuser);
            got.offset = rsp_tdata[14:0];
            got.level = rsp_tdata[18:15];
            got.free_bytes = rsp_tdata[34:19];
            case (got.status)
               R_ALLOC:   alloc_seen <= alloc_seen + 1;
               R_FREED:   freed_seen <= freed_seen + 1;
               R_REFUSED: refused_seen <= refused_seen + 1;
               default:   ignored_seen <= ignored_seen + 1;
            endcase
            if (awaited.size() == 0) begin
               $display("%0t: unexpected result word status=%0d offset=%0d level=%0d free=%0d",
                        $time, got.status, got.offset, got.level, got.free_bytes);
               fail_count <= fail_count + 1;
            end else begin
               want = awaited.pop_front();
               if (want != got) begin
                  $display("%0t: mismatch expected status=%0d offset=%0d level=%0d free=%0d",
                           $time, want.status, want.offset, want.level, want.free_bytes);
                  $display("%0t:          actual   status=%0d offset=%0d level=%0d free=%0d",
                           $time, got.status, got.offset, got.level, got.free_bytes);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// ----- tb/tb_buddy_allocator.sv -----
// Testbench top for the buddy allocator: clock, reset, stimulus and verdict.
module tb_buddy_allocator;
   import bud_alloc_pkg::*;

   localparam int LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // request_size[31:0], user_offset[46:32]
   logic        req_tuser = 1'b0; // operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // granted_offset[14:0], granted_level[18:15],
                                  // free_bytes[34:19]
   logic [1:0]  rsp_tuser;        // status
   int fail_count, pending, alloc_seen, freed_seen, refused_seen, ignored_seen;
   int cycles = 0;
   int idle_pct = 0;
   int stall_pct = 0;
   int sent = 0;
   logic [14:0] live[$];

   buddy_allocator dut (.*);

   buddy_allocator_checker chk (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hold the run within a generous cycle budget
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // random receiver stalls
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= stall_pct);

   // present one word, with a random idle gap, and wait for its handshake;
   // valid stays high afterwards so words can follow back to back
   task automatic send_word(op_type op, logic [31:0] size, logic [14:0] uoff);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {1'b0, uoff, size};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   task automatic alloc_word(logic [31:0] size);
      send_word(OP_ALLOC, size, 15'($urandom));
   endtask

   task automatic free_word(logic [14:0] uoff);
      send_word(OP_FREE, $urandom, uoff);
   endtask

   // size that mostly fits small levels, sometimes large or oversized
   function automatic logic [31:0] pick_size();
      int k;
      k = $urandom_range(99);
      if (k < 70) return $urandom_range(1, 200);
      if (k < 88) return $urandom_range(1, 4000);
      if (k < 95) return $urandom_range(1, 32744);
      return $urandom;
   endfunction

   // track granted offsets by peeking at results the checker also sees
   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready && rstat_type'(rsp_tuser) == R_ALLOC)
         live.push_back(rsp_tdata[14:0]);

   initial begin
      int k, idx;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes and special cases
      alloc_word(32'd0);
      alloc_word(32'hFFFF_FFFF);
      alloc_word(32'd32745);
      alloc_word(32'd32744);
      alloc_word(32'd1);
      free_word(15'd24);
      free_word(15'd24);
      alloc_word(32'd8);
      alloc_word(32'd9);
      free_word(15'd0);
      free_word(15'd23);
      free_word(15'd25);
      free_word(15'h7FFF);
      free_word(15'd32760);
      free_word(15'd56);
      alloc_word(32'd40);
      alloc_word(32'd1000);
      free_word(15'd24);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      live.delete();
      for (int i = 0; i < 6; i++) free_word(15'(24 + 32 * i * 2));

      // random phases with differing idling and receiver stalls
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 60; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 60; end
            3: begin idle_pct = 36; stall_pct = 36; end
            default: begin idle_pct = 0; stall_pct = 0; end
         endcase
         for (int n = 0; n < 110; n++) begin
            k = $urandom_range(99);
            if (k < 50) alloc_word(pick_size());
            else if (k < 88 && live.size() != 0) begin
               idx = $urandom_range(live.size() - 1);
               free_word(live[idx]);
               live.delete(idx);
            end else if (k < 94 && live.size() != 0)
               free_word(live[$urandom_range(live.size() - 1)] + 15'($urandom_range(1, 40)));
            else free_word(15'($urandom));
         end
      end

      req_tvalid <= 1'b0;
      stall_pct = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      $display("covered %0d requests: %0d granted, %0d freed, %0d refused, %0d ignored",
               sent, alloc_seen, freed_seen, refused_seen, ignored_seen);
      if (fail_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
